@@ rtl/qolb_pkg.sv @@
package qolb_pkg;

	localparam int OCC_W    = 12;
	localparam int NW_W     = 5;
	localparam int MARGIN_W = 8;
	localparam int IDX_W    = 4;
	localparam int CFG_A_W  = 2;
	localparam int CFG_D_W  = 8;
	localparam int IN_TD_W  = 16;
	localparam int OUT_TD_W = 8;

	localparam logic [NW_W-1:0]     NUM_WORKERS_RST = 5'd9;
	localparam logic [MARGIN_W-1:0] MARGIN_RST      = 8'd10;

	typedef enum logic [CFG_A_W-1:0] {
		REG_NUM_WORKERS = 2'd0,
		REG_MARGIN      = 2'd1
	} reg_idx_t;

	// settings seen by the datapath
	typedef struct packed {
		logic [NW_W-1:0]     workers;
		logic [MARGIN_W-1:0] margin;
		logic                restart;
	} cfg_t;

endpackage

@@ rtl/queue_occupancy_load_balancer_top.sv @@
// queue occupancy load balancer
// each transfer on the s_axis channel carries the fill level of the worker queue
// probed now; workers are probed round robin. for every input transfer exactly one
// result leaves on m_axis: the index of the probed worker and a dispatch flag that
// is set when occupancy*workers - margin < sum of the last workers occupancies
// (the sum counts as zero until the window has filled since the last restart).
// the cfg channel writes num_workers (index 0) and margin (index 1); it is always
// ready; the user must write it only while no item is in flight, as the block
// itself does not enforce this. a num_workers write restarts the window and the
// worker pointer. an input transfer is captured in the input register, then the
// result register presents the result on m_axis.
// throughput: one item per cycle while the receiver does not stall, set by the
// ring and sum update between the two registers.
// reset: window sum, fill count and pointers clear, num_workers returns to 9 and
// margin to 10; ring contents are not cleared.
// when the receiver stalls the result register holds, the input register fills and
// s_axis_tready then drops until the result is taken.
module queue_occupancy_load_balancer_top import qolb_pkg::*; #(
	parameter int MAX_WORKERS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [IN_TD_W-1:0]  s_axis_tdata,   // [11:0] occupancy
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [OUT_TD_W-1:0] m_axis_tdata,   // [3:0] worker_index, [4] dispatch
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_A_W-1:0]  cfg_addr,
	input  logic [CFG_D_W-1:0]  cfg_data
);

	localparam int PW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int SW = OCC_W + PW;
	localparam int PRW = OCC_W + NW_W;
	localparam int CW = ((SW > PRW) ? SW : PRW) + 2;

	cfg_t             cfg;
	logic             valid_s1;
	logic [OCC_W-1:0] occ_s1;
	logic             valid_s2;
	logic [IDX_W-1:0] index_s2;
	logic             dispatch_s2;
	logic             advance;
	logic             step;
	logic [PW-1:0]    worker_idx;
	logic [SW-1:0]    dec_sum;
	logic [PRW-1:0]   scaled;
	logic [CW-1:0]    lhs;
	logic [CW-1:0]    rhs;
	logic             dispatch;

	qolb_cfg #(
		.MAX_WORKERS(MAX_WORKERS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign advance       = !valid_s2 || m_axis_tready;
	assign step          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	qolb_window #(
		.MAX_WORKERS(MAX_WORKERS),
		.PW         (PW),
		.SW         (SW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.occupancy (occ_s1),
		.worker_idx(worker_idx),
		.dec_sum   (dec_sum)
	);

	// occ*w - margin < sum rewritten as occ*w < sum + margin
	assign scaled   = PRW'(occ_s1) * PRW'(cfg.workers);
	assign lhs      = CW'(scaled);
	assign rhs      = CW'(dec_sum) + CW'(cfg.margin);
	assign dispatch = lhs < rhs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			occ_s1 <= s_axis_tdata[OCC_W-1:0];
		end
		if (step) begin
			index_s2    <= IDX_W'(worker_idx);
			dispatch_s2 <= dispatch;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TD_W - IDX_W - 1){1'b0}}, dispatch_s2, index_s2};

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_item_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("stepped item did not reach result register");

	a_no_step_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!valid_s1 && m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
		else $error("result produced without an item");

endmodule

@@ rtl/qolb_cfg.sv @@
module qolb_cfg import qolb_pkg::*; #(
	parameter int MAX_WORKERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_D_W-1:0] cfg_data,
	output cfg_t               cfg
);

	localparam logic [6:0] MAX_W = 7'(MAX_WORKERS);

	logic [NW_W-1:0]     num_workers_q;
	logic [MARGIN_W-1:0] margin_q;
	logic [NW_W-1:0]     eff_workers;
	logic                wr_workers;
	logic                wr_margin;

	assign cfg_ready = 1'b1;

	always_comb begin
		wr_workers = 1'b0;
		wr_margin  = 1'b0;
		case (cfg_addr)
			REG_NUM_WORKERS: wr_workers = cfg_valid;
			REG_MARGIN:      wr_margin  = cfg_valid;
			default: begin
				wr_workers = 1'b0;
				wr_margin  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_workers_q <= NUM_WORKERS_RST;
			margin_q      <= MARGIN_RST;
		end else begin
			if (wr_workers) begin
				num_workers_q <= cfg_data[NW_W-1:0];
			end
			if (wr_margin) begin
				margin_q <= cfg_data[MARGIN_W-1:0];
			end
		end
	end

	// zero acts as one, clamp to the ring depth
	always_comb begin
		eff_workers = num_workers_q;
		if (num_workers_q == '0) begin
			eff_workers = NW_W'(1);
		end else if ({2'b00, num_workers_q} > MAX_W) begin
			eff_workers = NW_W'(MAX_W);
		end
	end

	assign cfg.workers = eff_workers;
	assign cfg.margin  = margin_q;
	assign cfg.restart = wr_workers;

	a_workers_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.workers != '0 && {2'b00, cfg.workers} <= MAX_W)
		else $error("effective worker count out of range");

	a_restart_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		wr_workers |=> num_workers_q == $past(cfg_data[NW_W-1:0]))
		else $error("worker count not taken from write");

	a_margin_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!wr_margin |=> $stable(margin_q))
		else $error("margin changed without a write");

endmodule

@@ rtl/qolb_window.sv @@
module qolb_window import qolb_pkg::*; #(
	parameter int MAX_WORKERS = 16,
	parameter int PW          = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
	parameter int SW          = OCC_W + PW
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             step,
	input  logic [OCC_W-1:0] occupancy,
	output logic [PW-1:0]    worker_idx,
	output logic [SW-1:0]    dec_sum
);

	localparam int XW = 8;

	logic [OCC_W-1:0] ring_q [MAX_WORKERS];
	logic [SW-1:0]    sum_q;
	logic [NW_W-1:0]  fill_q;
	logic [PW-1:0]    ring_ptr_q;
	logic [PW-1:0]    work_ptr_q;

	logic             full;
	logic [SW-1:0]    sum_nxt;
	logic [PW-1:0]    ring_ptr_nxt;
	logic [PW-1:0]    work_ptr_nxt;
	logic [XW-1:0]    w_x;

	assign w_x  = XW'(cfg.workers);
	assign full = fill_q >= cfg.workers;

	always_comb begin
		if (full) begin
			sum_nxt = sum_q + SW'(occupancy) - SW'(ring_q[ring_ptr_q]);
		end else begin
			sum_nxt = sum_q + SW'(occupancy);
		end
		ring_ptr_nxt = (XW'(ring_ptr_q) + XW'(1) >= w_x) ? '0 : ring_ptr_q + PW'(1);
		work_ptr_nxt = (XW'(work_ptr_q) + XW'(1) >= w_x) ? '0 : work_ptr_q + PW'(1);
	end

	assign worker_idx = work_ptr_q;
	assign dec_sum    = full ? sum_nxt : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			fill_q     <= '0;
			ring_ptr_q <= '0;
			work_ptr_q <= '0;
		end else if (cfg.restart) begin
			sum_q      <= '0;
			fill_q     <= '0;
			ring_ptr_q <= '0;
			work_ptr_q <= '0;
		end else if (step) begin
			sum_q      <= sum_nxt;
			ring_ptr_q <= ring_ptr_nxt;
			work_ptr_q <= work_ptr_nxt;
			if (!full) begin
				fill_q <= fill_q + NW_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !cfg.restart) begin
			ring_q[ring_ptr_q] <= occupancy;
		end
	end

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cfg.workers)
		else $error("fill count beyond window length");

	a_ptrs_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		XW'(ring_ptr_q) < w_x && XW'(work_ptr_q) < w_x)
		else $error("pointer outside window");

	a_fill_tracks_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		!full |-> XW'(ring_ptr_q) == XW'(fill_q))
		else $error("ring pointer and fill count disagree while filling");

endmodule

@@ sim/queue_occupancy_load_balancer_top_test.sv @@
`timescale 1ns / 100ps

module queue_occupancy_load_balancer_top_test;
	import qolb_pkg::*;

	localparam int MAX_WORKERS  = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TOTAL_PROBES = 1850;

	// register indexes with no register behind them
	localparam logic [CFG_A_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_A_W-1:0] REG_SPARE_B = 2'd3;
	localparam logic [OCC_W-1:0]   OCC_MAX     = '1;
	localparam logic [OCC_W-1:0]   OCC_HALF    = 12'd2048;

	typedef struct packed {
		logic             dispatch;
		logic [IDX_W-1:0] worker;
	} decision_t;

	class balance_scoreboard;
		logic [OCC_W-1:0]    occ_history [MAX_WORKERS];
		int                  occ_total;
		int                  samples;
		int                  slot_ptr;
		int                  next_worker;
		logic [NW_W-1:0]     workers_cfg;
		logic [MARGIN_W-1:0] bias;
		decision_t           pending_decisions [$];
		int                  errors;

		function new();
			foreach (occ_history[i])
				occ_history[i] = '0;
			restart_window();
			workers_cfg = NUM_WORKERS_RST;
			bias        = MARGIN_RST;
			errors      = 0;
		endfunction

		function void restart_window();
			occ_total   = 0;
			samples     = 0;
			slot_ptr    = 0;
			next_worker = 0;
		endfunction

		function int window_len();
			if (workers_cfg == 0)
				return 1;
			if (workers_cfg > MAX_WORKERS)
				return MAX_WORKERS;
			return int'(workers_cfg);
		endfunction

		function void write_reg(logic [CFG_A_W-1:0] addr, logic [CFG_D_W-1:0] data);
			if (addr == REG_NUM_WORKERS) begin
				workers_cfg = data[NW_W-1:0];
				restart_window();
			end else if (addr == REG_MARGIN) begin
				bias = data[MARGIN_W-1:0];
			end
		endfunction

		function void note_probe(logic [OCC_W-1:0] occ);
			int        w;
			int        occ_i;
			int        compare_sum;
			int        scaled;
			decision_t d;
			w     = window_len();
			occ_i = int'(occ);
			if (slot_ptr >= w)
				slot_ptr = 0;
			if (next_worker >= w)
				next_worker = 0;
			if (samples < w) begin
				occ_total   = occ_total + occ_i;
				samples     = samples + 1;
				compare_sum = 0;
			end else begin
				occ_total   = occ_total + occ_i - int'(occ_history[slot_ptr]);
				compare_sum = occ_total;
			end
			occ_history[slot_ptr] = occ;
			scaled     = occ_i * w - int'(bias);
			d.worker   = IDX_W'(next_worker);
			d.dispatch = scaled < compare_sum;
			pending_decisions.insert(pending_decisions.size(), d);
			slot_ptr    = (slot_ptr + 1 >= w) ? 0 : slot_ptr + 1;
			next_worker = (next_worker + 1 >= w) ? 0 : next_worker + 1;
		endfunction

		function void check_decision(logic [OUT_TD_W-1:0] tdata);
			decision_t want;
			if (pending_decisions.size() == 0) begin
				$error("result with nothing expected, tdata %0h", tdata);
				errors++;
				return;
			end
			want = pending_decisions.pop_front();
			if (tdata[IDX_W-1:0] !== want.worker) begin
				$error("worker_index: expected %0d, actual %0d", want.worker, tdata[IDX_W-1:0]);
				errors++;
			end
			if (tdata[IDX_W] !== want.dispatch) begin
				$error("dispatch: expected %0d, actual %0d", want.dispatch, tdata[IDX_W]);
				errors++;
			end
		endfunction
	endclass

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_TD_W-1:0]  s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_TD_W-1:0] m_axis_tdata;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CFG_A_W-1:0]  cfg_addr      = '0;
	logic [CFG_D_W-1:0]  cfg_data      = '0;

	balance_scoreboard sb = new();

	int cycles     = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int burst_left = 0;
	int gap_max    = 0;

	queue_occupancy_load_balancer_top #(
		.MAX_WORKERS(MAX_WORKERS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			sb.note_probe(s_axis_tdata[OCC_W-1:0]);
		if (m_axis_tvalid && m_axis_tready)
			sb.check_decision(m_axis_tdata);
		if (cfg_valid && cfg_ready)
			sb.write_reg(cfg_addr, cfg_data);
	end

	// receiver back-pressure
	always @(posedge clk) begin
		case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: begin
				if (stall_left > 0) begin
					stall_left--;
					m_axis_tready <= 1'b0;
				end else if ($urandom_range(0, 19) == 0) begin
					stall_left = $urandom_range(4, 24);
					m_axis_tready <= 1'b0;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic send_probe(input logic [OCC_W-1:0] occ);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_TD_W'(occ);
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// leaves cfg_valid high so back-to-back writes need only one assignment per step
	task automatic cfg_write(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_decisions.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [OCC_W-1:0] pick_occ(int level, int spread);
		int v;
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return OCC_MAX;
			2, 3:    return OCC_W'($urandom());
			default: begin
				v = level + int'($urandom_range(0, 2 * spread)) - spread;
				if (v < 0)
					v = 0;
				if (v > int'(OCC_MAX))
					v = int'(OCC_MAX);
				return OCC_W'(v);
			end
		endcase
	endfunction

	initial begin
		logic [OCC_W-1:0] directed [$];
		logic [NW_W-1:0]  nw;
		logic [CFG_D_W-1:0] mg;
		int sent;
		int phase_len;
		int level;
		int spread;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default settings: fill the window, then steady state
		directed = '{12'd0, OCC_MAX, OCC_HALF, 12'd1, 12'd2047, 12'hAAA, 12'h555,
			12'd100, 12'd90, 12'd0, OCC_MAX, 12'd0, 12'd5};
		foreach (directed[i])
			send_probe(directed[i]);
		wait_drained();

		// zero workers acts as one, widest margin
		cfg_write(REG_NUM_WORKERS, 8'hE0);
		cfg_write(REG_MARGIN, 8'hFF);
		cfg_valid <= 1'b0;
		send_probe(OCC_MAX);
		send_probe(12'd0);
		send_probe(12'd300);
		send_probe(OCC_HALF);
		wait_drained();

		// above the maximum acts as the maximum; spare indexes are ignored
		cfg_write(REG_NUM_WORKERS, 8'h1F);
		cfg_write(REG_MARGIN, 8'h00);
		cfg_write(REG_SPARE_A, 8'h03);
		cfg_write(REG_SPARE_B, 8'hFF);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 6; i++)
			send_probe(i[0] ? OCC_MAX : 12'd0);
		wait_drained();

		sent = 0;
		while (sent < TOTAL_PROBES) begin
			case ($urandom_range(0, 5))
				0:       nw = 5'd0;
				1:       nw = 5'd1;
				2:       nw = 5'd16;
				3:       nw = 5'($urandom_range(17, 31));
				default: nw = 5'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 3))
				0:       mg = 8'd0;
				1:       mg = 8'd255;
				default: mg = 8'($urandom());
			endcase
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_NUM_WORKERS, {3'($urandom()), nw});
			if ($urandom_range(0, 3) != 0)
				cfg_write(REG_MARGIN, mg);
			if ($urandom_range(0, 7) == 0)
				cfg_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 8'($urandom()));
			cfg_valid <= 1'b0;

			stall_mode = $urandom_range(0, 3);
			case ($urandom_range(0, 2))
				0:       gap_max = 0;
				1:       gap_max = 2;
				default: gap_max = 8;
			endcase
			burst_left = 0;

			phase_len = $urandom_range(10, 90);
			level     = $urandom_range(0, int'(OCC_MAX));
			spread    = $urandom_range(0, 1) ? $urandom_range(0, 16) : $urandom_range(0, 400);
			for (int i = 0; i < phase_len; i++)
				send_probe(pick_occ(level, spread));
			sent += phase_len;
			wait_drained();
		end

		stall_mode = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
